// File: hw/rtl/assert_macros.svh
// assertion macros used by the averager rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: hw/rtl/tcavg_pkg.sv
// types and constants of the time bucket channel averager
`timescale 1ns / 1ps
package tcavg_pkg;

	typedef struct packed {
		logic        opcode;
		logic [47:0] time_ms;
		logic [5:0]  channel;
		logic [2:0]  kind;
		logic [31:0] sample_value;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  out_channel;
		logic [31:0] avg_value;
		logic [47:0] bucket_start_ms;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [63:0] sum;
		logic [31:0] count;
		logic [2:0]  kind;
	} entry_t;

	typedef enum logic [0:0] {
		ALU_DIV = 1'b0,
		ALU_MUL = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef enum logic [1:0] {
		CFG_INTERVAL = 2'd0,
		CFG_PCT_UNK  = 2'd1,
		CFG_TEMP_UNK = 2'd2,
		CFG_CLK_UNK  = 2'd3
	} cfg_index_t;

	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [2:0] KIND_PCT  = 3'd0;
	localparam logic [2:0] KIND_TEMP = 3'd1;
	localparam logic [2:0] KIND_CLK  = 3'd2;
	localparam logic [2:0] KIND_U32  = 3'd3;
	localparam logic [2:0] KIND_U16  = 3'd4;

	localparam logic [63:0] PCT_CAP = 64'd100;
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

// File: hw/rtl/time_bucket_channel_averager.sv
// Tumbling-window averager over telemetry channels.
// Input channel in_valid/in_ready carries one in_data word: an accumulate
// (timestamp, channel, kind, value) or a flush. Output channel
// out_valid/out_ready carries one average per used channel, ascending, with
// last set on the final word of a bucket. Config writes come on
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// One item is worked at a time; in_ready is high only in the idle state.
// The bucket index is found by the shared radix-2 divider.
// An accumulate then reads its channel entry and writes it back to
// memory before the block returns to idle for the next item.
// Closing a bucket first finds the start time (shift-add multiply), then
// scans the channels in order; each used channel takes a memory read
// plus a 64-step divide (the divide is skipped when its count is zero),
// with the multiply and divides on the one shared unit.
// A stalled receiver holds the output register; the walk waits at the next
// result until the register frees.
// Reset clears the registers to their defaults and all channel-used bits;
// no clearing pass is needed, unused entries read as zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module time_bucket_channel_averager #(
	parameter int CHANNELS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tcavg_pkg::in_word_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tcavg_pkg::out_word_t  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_BDIV = 9'b000000010,
		ST_CMUL = 9'b000000100,
		ST_SCAN = 9'b000001000,
		ST_CRD  = 9'b000010000,
		ST_CDIV = 9'b000100000,
		ST_EMIT = 9'b001000000,
		ST_AUPD = 9'b010000000,
		ST_WAIT = 9'b100000000
	} state_t;

	state_t               state_q;
	tcavg_pkg::in_word_t  word_q;
	logic [31:0]          interval_q;
	logic [7:0]           pct_unk_q;
	logic [15:0]          temp_unk_q;
	logic [31:0]          clk_unk_q;
	logic [CHANNELS-1:0]  used_q;
	logic [47:0]          open_bucket_q;
	logic                 open_q;
	logic [47:0]          bucket_q;
	logic                 pend_add_q;
	logic [47:0]          start_q;
	logic [AW-1:0]        ch_q;
	logic [2:0]           ekind_q;
	logic                 neg_q;
	logic [31:0]          avg_q;
	logic                 out_valid_q;
	tcavg_pkg::out_word_t out_q;

	tcavg_pkg::alu_req_t  alu_req;
	logic [63:0]          alu_a;
	logic [31:0]          alu_b;
	logic                 alu_done;
	logic [63:0]          alu_res;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	tcavg_pkg::entry_t    rd_data;
	logic                 wr_en;
	tcavg_pkg::entry_t    wr_data;

	logic [AW-1:0]        in_ch;
	logic                 in_ok;
	logic                 load_out;
	logic [CHANNELS:0]    above;
	logic                 walk_last;
	logic                 scan_end;
	logic [63:0]          mag;
	logic [63:0]          crd_dividend;
	logic [31:0]          empty_avg;
	logic [31:0]          div_avg;
	tcavg_pkg::entry_t    old_ent;
	logic [63:0]          addend;
	logic                 skip;
	logic [15:0]          qneg;

	tcavg_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.done   (alu_done),
		.res    (alu_res)
	);

	tcavg_store #(
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (in_ch),
		.wr_data (wr_data)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign in_ch    = word_q.channel[AW-1:0];
	assign in_ok    = (interval_q != 32'd0) && (in_data.kind <= tcavg_pkg::KIND_U16)
		&& ({1'b0, in_data.channel} < 7'(CHANNELS));
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign above    = {1'b0, used_q} >> ch_q;
	assign walk_last = ~|above[CHANNELS:1];
	assign scan_end  = (ch_q == AW'(CHANNELS - 1));

	// channel average inputs
	assign mag = rd_data.sum[63] ? (64'd0 - rd_data.sum) : rd_data.sum;
	assign crd_dividend = (rd_data.kind == tcavg_pkg::KIND_TEMP) ? mag
		: rd_data.sum + {33'd0, rd_data.count[31:1]};
	assign qneg = 16'd0 - alu_res[15:0];

	always_comb begin
		case (rd_data.kind)
			tcavg_pkg::KIND_PCT:  empty_avg = {24'd0, pct_unk_q};
			tcavg_pkg::KIND_TEMP: empty_avg = {16'd0, temp_unk_q};
			tcavg_pkg::KIND_CLK:  empty_avg = clk_unk_q;
			default:              empty_avg = 32'd0;
		endcase
	end

	always_comb begin
		case (ekind_q)
			tcavg_pkg::KIND_PCT:
				div_avg = (alu_res > tcavg_pkg::PCT_CAP) ? tcavg_pkg::PCT_CAP[31:0]
					: alu_res[31:0];
			tcavg_pkg::KIND_TEMP: begin
				if (neg_q) begin
					div_avg = (alu_res > 64'd32768) ? {16'd0, temp_unk_q} : {16'd0, qneg};
				end else begin
					div_avg = (alu_res > 64'd32767) ? {16'd0, temp_unk_q}
						: alu_res[31:0];
				end
			end
			tcavg_pkg::KIND_CLK, tcavg_pkg::KIND_U32:
				div_avg = (alu_res[63:32] != 32'd0) ? 32'hFFFF_FFFF : alu_res[31:0];
			default:
				div_avg = (alu_res > 64'd65535) ? 32'h0000_FFFF : alu_res[31:0];
		endcase
	end

	// read-modify-write of one channel
	always_comb begin
		old_ent = used_q[in_ch] ? rd_data : '0;
		skip    = 1'b0;
		case (word_q.kind)
			tcavg_pkg::KIND_PCT: begin
				addend = {56'd0, word_q.sample_value[7:0]};
				skip   = (word_q.sample_value[7:0] == pct_unk_q);
			end
			tcavg_pkg::KIND_TEMP: begin
				addend = {{48{word_q.sample_value[15]}}, word_q.sample_value[15:0]};
				skip   = (word_q.sample_value[15:0] == temp_unk_q);
			end
			tcavg_pkg::KIND_CLK: begin
				addend = {32'd0, word_q.sample_value};
				skip   = (word_q.sample_value == clk_unk_q);
			end
			tcavg_pkg::KIND_U32: addend = {32'd0, word_q.sample_value};
			default:             addend = {48'd0, word_q.sample_value[15:0]};
		endcase
		if (old_ent.count == tcavg_pkg::CNT_MAX) begin
			skip = 1'b1;
		end
		wr_data.kind  = word_q.kind;
		wr_data.sum   = skip ? old_ent.sum : old_ent.sum + addend;
		wr_data.count = skip ? old_ent.count : old_ent.count + 32'd1;
		wr_en = (state_q == ST_AUPD);
	end

	always_comb begin
		alu_req.start = 1'b0;
		alu_req.op    = tcavg_pkg::ALU_DIV;
		alu_a         = {16'd0, word_q.time_ms};
		alu_b         = interval_q;
		rd_en         = 1'b0;
		rd_addr       = ch_q;
		unique case (state_q)
			ST_IDLE: begin
				alu_a = {16'd0, in_data.time_ms};
				if (in_valid) begin
					if (in_data.opcode == tcavg_pkg::OP_FLUSH) begin
						alu_req.start = open_q;
						alu_req.op    = tcavg_pkg::ALU_MUL;
						alu_a         = {16'd0, open_bucket_q};
					end else begin
						alu_req.start = in_ok;
					end
				end
			end
			ST_BDIV: begin
				if (alu_done) begin
					if (open_q && alu_res[47:0] != open_bucket_q) begin
						alu_req.start = 1'b1;
						alu_req.op    = tcavg_pkg::ALU_MUL;
						alu_a         = {16'd0, open_bucket_q};
					end else begin
						rd_en   = 1'b1;
						rd_addr = in_ch;
					end
				end
			end
			ST_SCAN: rd_en = used_q[ch_q];
			ST_CRD: begin
				alu_req.start = (rd_data.count != 32'd0);
				alu_a         = crd_dividend;
				alu_b         = rd_data.count;
			end
			ST_EMIT: begin
				if (load_out && (walk_last || scan_end) && pend_add_q) begin
					rd_en   = 1'b1;
					rd_addr = in_ch;
				end
			end
			ST_CMUL, ST_CDIV, ST_AUPD, ST_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 32'd1000;
			pct_unk_q  <= 8'd255;
			temp_unk_q <= 16'h8000;
			clk_unk_q  <= 32'd0;
		end else if (cfg_valid) begin
			unique case (tcavg_pkg::cfg_index_t'(cfg_index))
				tcavg_pkg::CFG_INTERVAL: interval_q <= cfg_data;
				tcavg_pkg::CFG_PCT_UNK:  pct_unk_q  <= cfg_data[7:0];
				tcavg_pkg::CFG_TEMP_UNK: temp_unk_q <= cfg_data[15:0];
				tcavg_pkg::CFG_CLK_UNK:  clk_unk_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			used_q        <= '0;
			open_q        <= 1'b0;
			open_bucket_q <= '0;
			pend_add_q    <= 1'b0;
			ch_q          <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_data.opcode == tcavg_pkg::OP_FLUSH) begin
							pend_add_q <= 1'b0;
							if (open_q) begin
								state_q <= ST_CMUL;
							end
						end else if (in_ok) begin
							state_q <= ST_BDIV;
						end
					end
				end
				ST_BDIV: begin
					if (alu_done) begin
						if (open_q && alu_res[47:0] != open_bucket_q) begin
							pend_add_q <= 1'b1;
							state_q    <= ST_CMUL;
						end else begin
							open_q        <= 1'b1;
							open_bucket_q <= alu_res[47:0];
							state_q       <= ST_AUPD;
						end
					end
				end
				ST_CMUL: begin
					if (alu_done) begin
						ch_q    <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (used_q[ch_q]) begin
						state_q <= ST_CRD;
					end else if (scan_end) begin
						used_q  <= '0;
						open_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						ch_q <= ch_q + AW'(1);
					end
				end
				ST_CRD: state_q <= (rd_data.count != 32'd0) ? ST_CDIV : ST_EMIT;
				ST_CDIV: begin
					if (alu_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						if (walk_last || scan_end) begin
							used_q     <= '0;
							pend_add_q <= 1'b0;
							if (pend_add_q) begin
								open_q        <= 1'b1;
								open_bucket_q <= bucket_q;
								state_q       <= ST_WAIT;
							end else begin
								open_q  <= 1'b0;
								state_q <= ST_IDLE;
							end
						end else begin
							ch_q    <= ch_q + AW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_WAIT: state_q <= ST_AUPD;
				ST_AUPD: begin
					used_q[in_ch] <= 1'b1;
					state_q       <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			word_q <= in_data;
		end
		if (state_q == ST_BDIV && alu_done) begin
			bucket_q <= alu_res[47:0];
		end
		if (state_q == ST_CMUL && alu_done) begin
			start_q <= alu_res[47:0];
		end
		if (state_q == ST_CRD) begin
			ekind_q <= rd_data.kind;
			neg_q   <= rd_data.sum[63];
			avg_q   <= empty_avg;
		end
		if (state_q == ST_CDIV && alu_done) begin
			avg_q <= div_avg;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.out_channel     <= 6'(ch_q);
			out_q.avg_value       <= avg_q;
			out_q.bucket_start_ms <= start_q;
			out_q.last            <= walk_last;
		end
	end

	`ASSERT_IMPLIES(a_walk_open, clk, arst_n, state_q == ST_SCAN || state_q == ST_EMIT, open_q)
	`ASSERT_IMPLIES(a_idle_no_pend, clk, arst_n, state_q == ST_IDLE, !pend_add_q)
	`ASSERT_NEXT(a_last_clears, clk, arst_n, load_out && walk_last, used_q == '0)
endmodule

// File: hw/rtl/tcavg_alu.sv
// shared iterative divider and shift-add multiplier
`timescale 1ns / 1ps
module tcavg_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  tcavg_pkg::alu_req_t req,
	input  logic [63:0]         a,
	input  logic [31:0]         b,
	output logic                done,
	output logic [63:0]         res
);
	logic                busy_q;
	logic                done_q;
	tcavg_pkg::alu_op_t  op_q;
	logic [5:0]          cnt_q;
	logic [63:0]         quo_q;
	logic [31:0]         rem_q;
	logic [31:0]         b_q;
	logic [47:0]         acc_q;
	logic [47:0]         mc_q;
	logic [32:0]         trial;
	logic [32:0]         diff;
	logic                fits;

	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, b_q};
	assign fits  = (trial >= {1'b0, b_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 6'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			cnt_q <= (req.op == tcavg_pkg::ALU_DIV) ? 6'd63 : 6'd31;
			quo_q <= a;
			rem_q <= '0;
			b_q   <= b;
			acc_q <= '0;
			mc_q  <= a[47:0];
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (op_q == tcavg_pkg::ALU_DIV) begin
				quo_q <= {quo_q[62:0], fits};
				rem_q <= fits ? diff[31:0] : trial[31:0];
			end else begin
				if (b_q[0]) begin
					acc_q <= acc_q + mc_q;
				end
				mc_q <= {mc_q[46:0], 1'b0};
				b_q  <= {1'b0, b_q[31:1]};
			end
		end
	end

	assign done = done_q;
	assign res  = (op_q == tcavg_pkg::ALU_DIV) ? quo_q : {16'd0, acc_q};
endmodule

// File: hw/rtl/tcavg_store.sv
// per-channel sum, count and kind memory
`timescale 1ns / 1ps
module tcavg_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output tcavg_pkg::entry_t     rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  tcavg_pkg::entry_t     wr_data
);
	tcavg_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: tb/sv/testbench.sv
// self-checking testbench of the time bucket channel averager
`timescale 1ns / 1ps
module testbench;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tcavg_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tcavg_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = tcavg_pkg::CFG_INTERVAL;
	logic [31:0] cfg_data = '0;

	time_bucket_channel_averager DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the block state and registers
	logic [31:0] interval_r;
	logic [7:0]  pct_code;
	logic [15:0] temp_code;
	logic [31:0] clk_code;
	logic [63:0] acc_sum [64];
	logic [31:0] acc_cnt [64];
	logic [2:0]  acc_kind [64];
	logic        acc_used [64];
	logic [47:0] cur_bucket;
	logic        bucket_open;

	tcavg_pkg::in_word_t  pending_words [$];
	tcavg_pkg::out_word_t averages_due [$];
	int errors = 0;
	int accepted = 0;
	int send_idle = 24;
	int recv_idle = 45;
	bit in_fire = 1'b0;

	function automatic void clear_window();
		for (int i = 0; i < 64; i++) begin
			acc_sum[i] = '0;
			acc_cnt[i] = '0;
			acc_kind[i] = tcavg_pkg::KIND_PCT;
			acc_used[i] = 1'b0;
		end
		cur_bucket = '0;
		bucket_open = 1'b0;
	endfunction

	function automatic logic [63:0] round_div(logic [63:0] s, logic [31:0] c);
		return (s + {33'd0, c[31:1]}) / {32'd0, c};
	endfunction

	function automatic logic [31:0] window_average(int ch);
		logic [63:0] s, a, mag, q;
		logic [31:0] c;
		logic neg;
		s = acc_sum[ch];
		c = acc_cnt[ch];
		case (acc_kind[ch])
			tcavg_pkg::KIND_PCT: begin
				if (c == 32'd0) return {24'd0, pct_code};
				a = round_div(s, c);
				return (a > tcavg_pkg::PCT_CAP) ? 32'd100 : a[31:0];
			end
			tcavg_pkg::KIND_TEMP: begin
				if (c == 32'd0) return {16'd0, temp_code};
				neg = s[63];
				mag = neg ? (64'd0 - s) : s;
				q = mag / {32'd0, c};
				if (neg ? (q > 64'd32768) : (q > 64'd32767)) return {16'd0, temp_code};
				a = neg ? (64'd0 - q) : q;
				return {16'd0, a[15:0]};
			end
			tcavg_pkg::KIND_CLK: begin
				if (c == 32'd0) return clk_code;
				a = round_div(s, c);
				return (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
			end
			tcavg_pkg::KIND_U32: begin
				if (c == 32'd0) return '0;
				a = round_div(s, c);
				return (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
			end
			default: begin
				if (c == 32'd0) return '0;
				a = round_div(s, c);
				return (a > 64'hFFFF) ? 32'h0000_FFFF : a[31:0];
			end
		endcase
	endfunction

	function automatic void close_window();
		logic [63:0] st;
		tcavg_pkg::out_word_t w;
		int n;
		if (!bucket_open) return;
		st = {16'd0, cur_bucket} * {32'd0, interval_r};
		n = 0;
		for (int ch = 0; ch < 64; ch++) begin
			if (acc_used[ch]) begin
				w.out_channel = ch[5:0];
				w.avg_value = window_average(ch);
				w.bucket_start_ms = st[47:0];
				w.last = 1'b0;
				averages_due.push_back(w);
				n++;
			end
		end
		if (n > 0) averages_due[$].last = 1'b1;
		clear_window();
	endfunction

	function automatic void predict_word(tcavg_pkg::in_word_t w);
		logic [47:0] b;
		logic [63:0] add;
		logic skip;
		int ch;
		if (w.opcode == tcavg_pkg::OP_FLUSH) begin
			close_window();
			return;
		end
		if (interval_r == 32'd0 || w.kind > tcavg_pkg::KIND_U16) return;
		b = w.time_ms / {16'd0, interval_r};
		if (bucket_open && b != cur_bucket) close_window();
		if (!bucket_open) begin
			cur_bucket = b;
			bucket_open = 1'b1;
		end
		ch = int'(w.channel);
		acc_used[ch] = 1'b1;
		acc_kind[ch] = w.kind;
		skip = 1'b0;
		case (w.kind)
			tcavg_pkg::KIND_PCT: begin
				add = {56'd0, w.sample_value[7:0]};
				skip = (w.sample_value[7:0] == pct_code);
			end
			tcavg_pkg::KIND_TEMP: begin
				add = {{48{w.sample_value[15]}}, w.sample_value[15:0]};
				skip = (w.sample_value[15:0] == temp_code);
			end
			tcavg_pkg::KIND_CLK: begin
				add = {32'd0, w.sample_value};
				skip = (w.sample_value == clk_code);
			end
			tcavg_pkg::KIND_U32: add = {32'd0, w.sample_value};
			default: add = {48'd0, w.sample_value[15:0]};
		endcase
		if (skip || acc_cnt[ch] == tcavg_pkg::CNT_MAX) return;
		acc_sum[ch] = acc_sum[ch] + add;
		acc_cnt[ch] = acc_cnt[ch] + 32'd1;
	endfunction

	// input driver
	always @(negedge clk) begin
		logic nv;
		tcavg_pkg::in_word_t nd;
		nv = in_valid;
		nd = in_data;
		if (in_fire) begin
			predict_word(in_data);
			accepted++;
			nv = 1'b0;
		end
		if (arst_n && !nv && pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
			nd = pending_words.pop_front();
			nv = 1'b1;
		end
		in_valid <= nv;
		in_data <= nd;
	end

	// output ready, with one long hold-off
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		if (!hold_done && accepted >= 120) begin
			hold_done = 1'b1;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// monitor
	always @(posedge clk) begin
		tcavg_pkg::out_word_t e;
		in_fire = in_valid && in_ready;
		if (out_valid && out_ready) begin
			if (averages_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word %h", out_data);
			end else begin
				e = averages_due.pop_front();
				if (out_data.out_channel !== e.out_channel || out_data.avg_value !== e.avg_value
						|| out_data.bucket_start_ms !== e.bucket_start_ms
						|| out_data.last !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected ch %0d avg %h start %h last %b, got ch %0d avg %h start %h last %b",
							e.out_channel, e.avg_value, e.bucket_start_ms, e.last,
							out_data.out_channel, out_data.avg_value,
							out_data.bucket_start_ms, out_data.last);
				end
			end
		end
	end

	function automatic tcavg_pkg::in_word_t acc_word(logic [47:0] t, logic [5:0] ch,
			logic [2:0] k, logic [31:0] v);
		tcavg_pkg::in_word_t w;
		w.opcode = tcavg_pkg::OP_ACCUM;
		w.time_ms = t;
		w.channel = ch;
		w.kind = k;
		w.sample_value = v;
		return w;
	endfunction

	function automatic tcavg_pkg::in_word_t flush_word();
		tcavg_pkg::in_word_t w;
		w = acc_word(48'({$urandom, $urandom}), 6'($urandom), 3'($urandom), $urandom);
		w.opcode = tcavg_pkg::OP_FLUSH;
		return w;
	endfunction

	task automatic write_reg(tcavg_pkg::cfg_index_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tcavg_pkg::CFG_INTERVAL: interval_r = val;
			tcavg_pkg::CFG_PCT_UNK:  pct_code = val[7:0];
			tcavg_pkg::CFG_TEMP_UNK: temp_code = val[15:0];
			default:                 clk_code = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid && averages_due.size() == 0);
		repeat (300) @(posedge clk);
		wait (in_ready && averages_due.size() == 0);
	endtask

	task automatic random_words(int n);
		logic [47:0] t;
		logic [31:0] v;
		logic [2:0] k;
		logic [5:0] ch;
		t = 48'({$urandom, $urandom});
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				pending_words.push_back(flush_word());
				continue;
			end
			case ($urandom_range(0, 9))
				0: t = 48'({$urandom, $urandom});
				1, 2: t = t + {16'd0, interval_r};
				default: ;
			endcase
			k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			ch = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
			case ($urandom_range(0, 5))
				0: v = $urandom;
				1: v = {24'd0, pct_code};
				2: v = {16'd0, temp_code};
				3: v = clk_code;
				4: v = $urandom_range(0, 120);
				default: v = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			endcase
			pending_words.push_back(acc_word(t, ch, k, v));
		end
	endtask

	initial begin
		interval_r = 32'd1000;
		pct_code = 8'd255;
		temp_code = 16'h8000;
		clk_code = 32'd0;
		clear_window();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: defaults, sentinels, caps, kind changes, bad kinds, flushes
		pending_words.push_back(flush_word());
		pending_words.push_back(acc_word(48'd10, 6'd0, tcavg_pkg::KIND_PCT, 32'd200));
		pending_words.push_back(acc_word(48'd11, 6'd0, tcavg_pkg::KIND_PCT, 32'h0000_00FF));
		pending_words.push_back(acc_word(48'd12, 6'd1, tcavg_pkg::KIND_PCT, 32'h0000_00FF));
		pending_words.push_back(acc_word(48'd13, 6'd2, tcavg_pkg::KIND_TEMP, 32'h0000_FFF6));
		pending_words.push_back(acc_word(48'd14, 6'd2, tcavg_pkg::KIND_TEMP, 32'hFFFF_FFFB));
		pending_words.push_back(acc_word(48'd15, 6'd3, tcavg_pkg::KIND_TEMP, 32'h0000_8000));
		pending_words.push_back(acc_word(48'd16, 6'd4, tcavg_pkg::KIND_CLK, 32'd0));
		pending_words.push_back(acc_word(48'd17, 6'd5, tcavg_pkg::KIND_CLK, 32'hFFFF_FFFF));
		pending_words.push_back(acc_word(48'd18, 6'd6, tcavg_pkg::KIND_U32, 32'hFFFF_FFFF));
		pending_words.push_back(acc_word(48'd19, 6'd6, tcavg_pkg::KIND_U32, 32'hFFFF_FFFE));
		pending_words.push_back(acc_word(48'd20, 6'd7, tcavg_pkg::KIND_U32, 32'hFFFF_FFFF));
		pending_words.push_back(acc_word(48'd21, 6'd7, tcavg_pkg::KIND_U16, 32'h1234_5678));
		pending_words.push_back(acc_word(48'd22, 6'd8, tcavg_pkg::KIND_U32, 32'hFFFF_FFFF));
		pending_words.push_back(acc_word(48'd23, 6'd8, tcavg_pkg::KIND_TEMP, 32'h0000_7FFF));
		pending_words.push_back(acc_word(48'd24, 6'd9, 3'd5, 32'd1));
		pending_words.push_back(acc_word(48'd25, 6'd9, 3'd7, 32'd1));
		pending_words.push_back(acc_word(48'd26, 6'd63, tcavg_pkg::KIND_U16, 32'hFFFF_FFFF));
		pending_words.push_back(acc_word(48'd1500, 6'd10, tcavg_pkg::KIND_PCT, 32'd3));
		pending_words.push_back(flush_word());
		pending_words.push_back(flush_word());
		pending_words.push_back(acc_word(48'hFFFF_FFFF_FFFF, 6'd62, tcavg_pkg::KIND_CLK, 32'd7));
		drain();

		write_reg(tcavg_pkg::CFG_INTERVAL, 32'd1);
		write_reg(tcavg_pkg::CFG_PCT_UNK, 32'd0);
		write_reg(tcavg_pkg::CFG_TEMP_UNK, 32'h0000_7FFF);
		write_reg(tcavg_pkg::CFG_CLK_UNK, 32'hFFFF_FFFF);
		pending_words.push_back(acc_word(48'hFFFF_FFFF_FFFF, 6'd1, tcavg_pkg::KIND_PCT, 32'd0));
		random_words(90);
		drain();

		write_reg(tcavg_pkg::CFG_INTERVAL, 32'hFFFF_FFFF);
		write_reg(tcavg_pkg::CFG_PCT_UNK, $urandom);
		write_reg(tcavg_pkg::CFG_TEMP_UNK, $urandom);
		write_reg(tcavg_pkg::CFG_CLK_UNK, $urandom);
		send_idle = 45;
		recv_idle = 24;
		random_words(90);
		drain();

		write_reg(tcavg_pkg::CFG_INTERVAL, 32'd0);
		random_words(20);
		pending_words.push_back(flush_word());
		drain();

		write_reg(tcavg_pkg::CFG_INTERVAL, 32'd7);
		write_reg(tcavg_pkg::CFG_PCT_UNK, 32'd50);
		write_reg(tcavg_pkg::CFG_TEMP_UNK, 32'h0000_FFFF);
		write_reg(tcavg_pkg::CFG_CLK_UNK, 32'd5);
		send_idle = 0;
		recv_idle = 0;
		random_words(100);
		pending_words.push_back(flush_word());
		drain();

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
